// ===== src/stkrm_pkg.sv =====
// Package for the bounded stack with remove-by-value.
// Holds widths, action and status codes, datapath command codes and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package stkrm_pkg;

  localparam int unsigned DepthDefault = 8;
  localparam int unsigned DataW        = 32;
  localparam int unsigned ActW         = 2;
  localparam int unsigned StatW        = 2;
  localparam int unsigned CountOutW    = 4;

  typedef enum logic [ActW-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_REMOVE = 2'd3
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_PUSH,
    DP_POP,
    DP_CLEAR,
    DP_FAIL,
    DP_SEARCH_INIT,
    DP_SEARCH_NEXT,
    DP_LOAD_TOP,
    DP_SHIFT_INIT,
    DP_SHIFT_STEP,
    DP_SHIFT_LAST
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic one;
    logic match;
    logic idx_zero;
    logic idx_top;
  } dp_stat_t;

endpackage

// ===== src/stkrm_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module stkrm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/stkrm_dp.sv =====
// Stack datapath: fill count, cached top word, search key, index and the
// entry RAM. Depends on stkrm_pkg and stkrm_ram.
`timescale 1ns / 1ps

module stkrm_dp #(
  parameter int unsigned Depth = stkrm_pkg::DepthDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  stkrm_pkg::dp_cmd_t                   cmd_i,
  input  logic signed [stkrm_pkg::DataW-1:0]   value_i,
  output stkrm_pkg::dp_stat_t                  stat_o,
  output logic [stkrm_pkg::StatW-1:0]          status_o,
  output logic [stkrm_pkg::CountOutW-1:0]      count_o,
  output logic                                 is_full_o,
  output logic                                 is_empty_o,
  output logic signed [stkrm_pkg::DataW-1:0]   top_word_o
);

  import stkrm_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          cnt_m1, cnt_m2;
  logic [AW-1:0]          idx_q, idx_d;
  logic [DataW-1:0]       key_q, key_d;
  logic [DataW-1:0]       top_q, top_d;
  status_e                status_q, status_d;
  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [DataW-1:0]       wdata, rdata;

  stkrm_ram #(
    .Width(DataW),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign cnt_m1 = count_q - CW'(1);
  assign cnt_m2 = count_q - CW'(2);

  always_comb begin
    count_d  = count_q;
    idx_d    = idx_q;
    key_d    = key_q;
    top_d    = top_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = idx_q - AW'(1);
    wdata    = rdata;
    raddr    = idx_q;
    case (cmd_i.op)
      DP_PUSH: begin
        we       = 1'b1;
        waddr    = count_q[AW-1:0];
        wdata    = value_i;
        top_d    = value_i;
        count_d  = count_q + CW'(1);
        status_d = ST_OK;
      end
      DP_POP: begin
        count_d  = cnt_m1;
        raddr    = cnt_m2[AW-1:0];
        status_d = ST_OK;
      end
      DP_CLEAR: begin
        count_d  = '0;
        status_d = ST_OK;
      end
      DP_FAIL: begin
        status_d = cmd_i.status;
      end
      DP_SEARCH_INIT: begin
        key_d = value_i;
        idx_d = cnt_m1[AW-1:0];
        raddr = cnt_m1[AW-1:0];
      end
      DP_SEARCH_NEXT: begin
        idx_d = idx_q - AW'(1);
        raddr = idx_q - AW'(1);
      end
      DP_LOAD_TOP: begin
        top_d = rdata;
      end
      DP_SHIFT_INIT: begin
        idx_d = idx_q + AW'(1);
        raddr = idx_q + AW'(1);
      end
      DP_SHIFT_STEP: begin
        we    = 1'b1;
        idx_d = idx_q + AW'(1);
        raddr = idx_q + AW'(1);
      end
      DP_SHIFT_LAST: begin
        we       = 1'b1;
        count_d  = cnt_m1;
        status_d = ST_OK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    key_q    <= key_d;
    top_q    <= top_d;
    status_q <= status_d;
  end

  assign stat_o.full     = (count_q == CW'(Depth));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.one      = (count_q == CW'(1));
  assign stat_o.match    = (rdata == key_q);
  assign stat_o.idx_zero = (idx_q == '0);
  assign stat_o.idx_top  = (idx_q == cnt_m1[AW-1:0]);

  assign status_o   = status_q;
  assign count_o    = CountOutW'(count_q);
  assign is_full_o  = stat_o.full;
  assign is_empty_o = stat_o.empty;
  assign top_word_o = stat_o.empty ? '0 : top_q;

endmodule

// ===== src/stkrm_ctrl.sv =====
// Stack controller: sequences push, pop, clear and the search/shift of
// remove-by-value. Depends on stkrm_pkg.
`timescale 1ns / 1ps

module stkrm_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [stkrm_pkg::ActW-1:0]   action_i,
  input  stkrm_pkg::dp_stat_t          stat_i,
  output stkrm_pkg::dp_cmd_t           cmd_o,
  output logic                         busy_o,
  output logic                         done_o
);

  import stkrm_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOAD  = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       done_q, done_d;

  always_comb begin
    state_d      = state_q;
    done_d       = 1'b0;
    cmd_o.op     = DP_NOP;
    cmd_o.status = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (action_i)
            ACT_PUSH: begin
              done_d = 1'b1;
              if (stat_i.full) begin
                cmd_o.op     = DP_FAIL;
                cmd_o.status = ST_FULL;
              end else begin
                cmd_o.op = DP_PUSH;
              end
            end
            ACT_POP: begin
              if (stat_i.empty) begin
                cmd_o.op     = DP_FAIL;
                cmd_o.status = ST_EMPTY;
                done_d       = 1'b1;
              end else begin
                cmd_o.op = DP_POP;
                if (stat_i.one) begin
                  done_d = 1'b1;
                end else begin
                  state_d = S_LOAD;
                end
              end
            end
            ACT_CLEAR: begin
              cmd_o.op = DP_CLEAR;
              done_d   = 1'b1;
            end
            default: begin
              if (stat_i.empty) begin
                cmd_o.op     = DP_FAIL;
                cmd_o.status = ST_NOT_FOUND;
                done_d       = 1'b1;
              end else begin
                cmd_o.op = DP_SEARCH_INIT;
                state_d  = S_CMP;
              end
            end
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.op = DP_LOAD_TOP;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      S_CMP: begin
        if (stat_i.match) begin
          if (stat_i.idx_top) begin
            // hit on the top entry behaves as a pop
            cmd_o.op = DP_POP;
            if (stat_i.one) begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              state_d = S_LOAD;
            end
          end else begin
            cmd_o.op = DP_SHIFT_INIT;
            state_d  = S_SHIFT;
          end
        end else if (stat_i.idx_zero) begin
          cmd_o.op     = DP_FAIL;
          cmd_o.status = ST_NOT_FOUND;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.op = DP_SEARCH_NEXT;
        end
      end
      S_SHIFT: begin
        if (stat_i.idx_top) begin
          cmd_o.op = DP_SHIFT_LAST;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = DP_SHIFT_STEP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== src/stack_with_remove_by_value.sv =====
// Bounded LIFO stack of signed 32-bit words with push, pop, clear and
// remove-by-value. Depends on stkrm_pkg, stkrm_ctrl and stkrm_dp.
//
// An item is taken when start_i is high and busy_o low. Its result appears
// for exactly one cycle with done_o high, and the receiver cannot stall it.
// Push, clear, a refused push or pop and a remove on an empty stack give
// their result in the cycle after the transfer and leave busy_o low. A pop
// that leaves entries behind also passes through S_LOAD, since the new top
// is read back from the entry RAM. Remove compares one entry per cycle from
// the top down in S_CMP; a miss gives its result once the bottom entry has
// been compared. A hit at index h (zero at the bottom) below the top then
// moves one entry per cycle above the hit down by one place in S_SHIFT. A
// hit on the top entry instead behaves as a pop and reads the new top in
// S_LOAD unless it was the only entry. These steps follow from the single
// read port of the entry RAM.
`timescale 1ns / 1ps

module stack_with_remove_by_value #(
  parameter int unsigned DEPTH = stkrm_pkg::DepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [stkrm_pkg::ActW-1:0]          action_i,
  input  logic signed [stkrm_pkg::DataW-1:0]  value_i,
  output logic                                done_o,
  output logic [stkrm_pkg::StatW-1:0]         status_o,
  output logic [stkrm_pkg::CountOutW-1:0]     count_o,
  output logic                                is_full_o,
  output logic                                is_empty_o,
  output logic signed [stkrm_pkg::DataW-1:0]  top_word_o
);

  import stkrm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  stkrm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .action_i(action_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  stkrm_dp #(
    .Depth(DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .value_i   (value_i),
    .stat_o    (stat),
    .status_o  (status_o),
    .count_o   (count_o),
    .is_full_o (is_full_o),
    .is_empty_o(is_empty_o),
    .top_word_o(top_word_o)
  );

endmodule
